/* hdl/tmsd_pkg.sv */
// Package for the three-way sorted merge unit: sizes, field widths,
// sequencer step codes, control and status words and the microcode table.
// No dependencies.
package tmsd_pkg;

  localparam int LIST_DEPTH = 16;
  localparam int NUM_LISTS  = 3;
  localparam int VAL_W      = 32;
  localparam int LIST_W     = 2;
  localparam int CNT_W      = 6;
  localparam int PTR_W      = $clog2(LIST_DEPTH + 1);
  localparam int ADDR_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int IN_DATA_W  = 32;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 40;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PRIME,
    ST_PICK,
    ST_FINISH
  } step_t;

  typedef enum logic [1:0] {
    C_ALWAYS,
    C_MERGE,
    C_EXHAUSTED
  } cond_t;

  typedef struct packed {
    logic  accept;
    logic  prime;
    logic  pick;
    logic  finish;
    cond_t cond;
    step_t jmp;
    step_t seq;
  } ctrl_t;

  typedef struct packed {
    logic merge_cmd;
    logic exhausted;
    logic stall;
  } status_t;

  function automatic ctrl_t ucode(step_t s);
    ctrl_t w;
    w = '{accept: 1'b0, prime: 1'b0, pick: 1'b0, finish: 1'b0,
          cond: C_ALWAYS, jmp: ST_IDLE, seq: ST_IDLE};
    case (s)
      ST_IDLE: begin
        w.accept = 1'b1;
        w.cond   = C_MERGE;
        w.jmp    = ST_PRIME;
        w.seq    = ST_IDLE;
      end
      ST_PRIME: begin
        w.prime = 1'b1;
        w.cond  = C_ALWAYS;
        w.jmp   = ST_PICK;
        w.seq   = ST_PICK;
      end
      ST_PICK: begin
        w.pick = 1'b1;
        w.cond = C_EXHAUSTED;
        w.jmp  = ST_FINISH;
        w.seq  = ST_PICK;
      end
      ST_FINISH: begin
        w.finish = 1'b1;
        w.cond   = C_ALWAYS;
        w.jmp    = ST_IDLE;
        w.seq    = ST_IDLE;
      end
      default: begin
        w.cond = C_ALWAYS;
        w.jmp  = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

/* hdl/tmsd_seq.sv */
// Microcode sequencer: step counter, control word fetch from the table
// and conditional jumps. Depends on tmsd_pkg.
module tmsd_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  tmsd_pkg::status_t sts,
  output tmsd_pkg::ctrl_t   ctrl
);

  tmsd_pkg::step_t step_r;
  tmsd_pkg::step_t step_nxt;
  logic            cond_hit;

  assign ctrl = tmsd_pkg::ucode(step_r);

  always_comb begin
    case (ctrl.cond)
      tmsd_pkg::C_ALWAYS:    cond_hit = 1'b1;
      tmsd_pkg::C_MERGE:     cond_hit = sts.merge_cmd;
      tmsd_pkg::C_EXHAUSTED: cond_hit = sts.exhausted;
      default:               cond_hit = 1'b0;
    endcase
    if (sts.stall) begin
      step_nxt = step_r;
    end else if (cond_hit) begin
      step_nxt = ctrl.jmp;
    end else begin
      step_nxt = ctrl.seq;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= tmsd_pkg::ST_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

/* hdl/three_way_sorted_merge_dedup_unit.sv */
// Three-way sorted merge with duplicate removal: top level with list
// memories, head compare and output register. Depends on tmsd_pkg, tmsd_seq.
//
// Appends (operation 0) are taken one per cycle and written into one of three
// list memories of LIST_DEPTH entries; zero values, list three and full lists
// are dropped silently. A merge command (operation 1) occupies the block until
// it is done: a prime step sets up the memory read ports, then the three-head
// compare loop consumes one element per cycle, a further pick step finds every
// list used up, then a finish step delivers the last item, which carries the
// distinct count (or the empty flag when no list held anything). in_tready stays
// low for the whole merge; the loop, when it has an item to emit, and the final
// step hold while the output register is full and not taken.
// All lists are empty after the merge.
module three_way_sorted_merge_dedup_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [tmsd_pkg::IN_DATA_W-1:0]  in_tdata,   // [31:0] value
  input  logic [tmsd_pkg::IN_USER_W-1:0]  in_tuser,   // [0] operation, [2:1] list_number
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [tmsd_pkg::OUT_DATA_W-1:0] out_tdata,  // [31:0] merged_value,
                                                      // [37:32] distinct_count, [39:38] zero
  output logic                            out_tlast,
  output logic                            out_tuser   // [0] is_empty
);

  localparam int NL = tmsd_pkg::NUM_LISTS;

  tmsd_pkg::ctrl_t   ctrl;
  tmsd_pkg::status_t sts;

  logic [tmsd_pkg::PTR_W-1:0]  fill_r   [NL];
  logic [tmsd_pkg::PTR_W-1:0]  fill_nxt [NL];
  logic [tmsd_pkg::PTR_W-1:0]  rd_r     [NL];
  logic [tmsd_pkg::PTR_W-1:0]  rd_nxt   [NL];
  logic [tmsd_pkg::VAL_W-1:0]  head_q   [NL];
  logic [NL-1:0]               wr_en;
  logic [NL-1:0]               head_ok;

  logic [tmsd_pkg::VAL_W-1:0]  pend_r, pend_nxt;
  logic                        pend_valid_r, pend_valid_nxt;
  logic [tmsd_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [tmsd_pkg::VAL_W-1:0]  out_val_r, out_val_nxt;
  logic [tmsd_pkg::CNT_W-1:0]  out_cnt_r, out_cnt_nxt;
  logic                        out_last_r, out_last_nxt;
  logic                        out_empty_r, out_empty_nxt;

  logic                        in_fire;
  logic                        out_free;
  logic                        found;
  logic [tmsd_pkg::VAL_W-1:0]  best_val;
  logic [NL-1:0]               best_sel;
  logic                        pick_act;
  logic                        dup;
  logic                        need_emit;
  logic [tmsd_pkg::VAL_W-1:0]  in_value;
  logic                        in_op;
  logic [tmsd_pkg::LIST_W-1:0] in_list;

  assign in_value = in_tdata[tmsd_pkg::VAL_W-1:0];
  assign in_op    = in_tuser[0];
  assign in_list  = in_tuser[tmsd_pkg::LIST_W:1];

  assign in_tready = ctrl.accept;
  assign in_fire   = in_tvalid & in_tready;
  assign out_free  = !out_valid_r || out_tready;

  tmsd_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .ctrl  (ctrl)
  );

  genvar g;
  generate
    for (g = 0; g < NL; g++) begin : g_list
      logic [tmsd_pkg::VAL_W-1:0] mem [tmsd_pkg::LIST_DEPTH];
      always_ff @(posedge clk) begin
        if (wr_en[g]) begin
          mem[fill_r[g][tmsd_pkg::ADDR_W-1:0]] <= in_value;
        end
        head_q[g] <= mem[rd_nxt[g][tmsd_pkg::ADDR_W-1:0]];
      end
      assign head_ok[g] = rd_r[g] < fill_r[g];
    end
  endgenerate

  always_comb begin
    found    = 1'b0;
    best_val = '0;
    best_sel = '0;
    for (int k = 0; k < NL; k++) begin
      if (head_ok[k] && (!found || $signed(head_q[k]) < $signed(best_val))) begin
        found    = 1'b1;
        best_val = head_q[k];
        best_sel = NL'(1) << k;
      end
    end
  end

  assign pick_act  = ctrl.pick && found;
  assign dup       = pend_valid_r && (best_val == pend_r);
  assign need_emit = pick_act && pend_valid_r && !dup;

  assign sts.merge_cmd = in_fire && in_op;
  assign sts.exhausted = !found;
  assign sts.stall     = ((need_emit || ctrl.finish) && !out_free);

  always_comb begin
    fill_nxt       = fill_r;
    rd_nxt         = rd_r;
    wr_en          = '0;
    pend_nxt       = pend_r;
    pend_valid_nxt = pend_valid_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_val_nxt    = out_val_r;
    out_cnt_nxt    = out_cnt_r;
    out_last_nxt   = out_last_r;
    out_empty_nxt  = out_empty_r;

    if (in_fire && !in_op && in_value != '0) begin
      for (int k = 0; k < NL; k++) begin
        if (in_list == tmsd_pkg::LIST_W'(k) &&
            fill_r[k] < tmsd_pkg::PTR_W'(tmsd_pkg::LIST_DEPTH)) begin
          wr_en[k]    = 1'b1;
          fill_nxt[k] = fill_r[k] + 1'b1;
        end
      end
    end

    if (ctrl.prime) begin
      for (int k = 0; k < NL; k++) begin
        rd_nxt[k] = '0;
      end
      pend_valid_nxt = 1'b0;
      cnt_nxt        = '0;
    end

    if (pick_act && !sts.stall) begin
      for (int k = 0; k < NL; k++) begin
        if (best_sel[k]) begin
          rd_nxt[k] = rd_r[k] + 1'b1;
        end
      end
      if (!dup) begin
        pend_nxt       = best_val;
        pend_valid_nxt = 1'b1;
        cnt_nxt        = cnt_r + 1'b1;
      end
      if (need_emit) begin
        out_valid_nxt = 1'b1;
        out_val_nxt   = pend_r;
        out_cnt_nxt   = '0;
        out_last_nxt  = 1'b0;
        out_empty_nxt = 1'b0;
      end
    end

    if (ctrl.finish && !sts.stall) begin
      out_valid_nxt = 1'b1;
      out_last_nxt  = 1'b1;
      if (pend_valid_r) begin
        out_val_nxt   = pend_r;
        out_cnt_nxt   = cnt_r;
        out_empty_nxt = 1'b0;
      end else begin
        out_val_nxt   = '0;
        out_cnt_nxt   = '0;
        out_empty_nxt = 1'b1;
      end
      for (int k = 0; k < NL; k++) begin
        fill_nxt[k] = '0;
        rd_nxt[k]   = '0;
      end
      pend_valid_nxt = 1'b0;
      cnt_nxt        = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NL; k++) begin
        fill_r[k] <= '0;
        rd_r[k]   <= '0;
      end
      pend_valid_r <= 1'b0;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      fill_r       <= fill_nxt;
      rd_r         <= rd_nxt;
      pend_valid_r <= pend_valid_nxt;
      cnt_r        <= cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    pend_r      <= pend_nxt;
    out_val_r   <= out_val_nxt;
    out_cnt_r   <= out_cnt_nxt;
    out_last_r  <= out_last_nxt;
    out_empty_r <= out_empty_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(tmsd_pkg::OUT_DATA_W - tmsd_pkg::VAL_W - tmsd_pkg::CNT_W){1'b0}},
                       out_cnt_r, out_val_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_empty_r;

endmodule

/* hdl/tmsd_checker.sv */
// Port-level checks for the three-way sorted merge unit, bound to its top
// level. Depends on tmsd_pkg and three_way_sorted_merge_dedup_unit.
module tmsd_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [tmsd_pkg::IN_USER_W-1:0]  in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [tmsd_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                            out_tlast,
  input logic                            out_tuser
);

  localparam int CNT_LO = tmsd_pkg::VAL_W;
  localparam int CNT_HI = tmsd_pkg::VAL_W + tmsd_pkg::CNT_W - 1;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tlast) && $stable(out_tuser))
    else $error("result item changed while stalled");

  a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && out_tdata == '0)
    else $error("empty result not a lone zero last item");

  a_mid_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[CNT_HI:CNT_LO] == '0 && !out_tuser)
    else $error("count on a non-last item");

  a_last_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast && !out_tuser |-> out_tdata[CNT_HI:CNT_LO] != '0)
    else $error("last item of a non-empty merge has zero count");

  a_merge_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser[0] |=> !in_tready)
    else $error("input taken straight after a merge command");

endmodule

bind three_way_sorted_merge_dedup_unit tmsd_checker u_tmsd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

/* tb/three_way_sorted_merge_dedup_unit_tb.sv */
// Self-checking bench for the three-way sorted merge unit: directed table, then random
// append/merge sequences with random stalls on both streams, checked by a merge predictor.
// Depends on tmsd_pkg and three_way_sorted_merge_dedup_unit.
module three_way_sorted_merge_dedup_unit_tb;

  localparam logic                        OP_APPEND       = 1'b0;
  localparam logic                        OP_MERGE        = 1'b1;
  localparam logic [tmsd_pkg::LIST_W-1:0] LIST_NONE       = 2'd3;
  localparam int  MAX_MERGED      = tmsd_pkg::NUM_LISTS * tmsd_pkg::LIST_DEPTH;
  localparam int  CYCLE_LIMIT     = 400000;
  localparam int  HOLD_OFF_CYCLES = 300;
  localparam int  DRAIN_CYCLES    = 8;
  localparam int  RANDOM_ITEMS    = 500;
  localparam int  NUM_ROWS        = 25;

  typedef enum int {SPREAD_WIDE, SPREAD_NARROW, SPREAD_EDGES} value_spread_t;

  typedef struct packed {
    logic signed [tmsd_pkg::VAL_W-1:0] value;
    logic                              last;
    logic [tmsd_pkg::CNT_W-1:0]        count;
    logic                              empty;
  } merge_result_t;

  typedef struct packed {
    logic                              op;
    logic [tmsd_pkg::LIST_W-1:0]       list;
    logic signed [tmsd_pkg::VAL_W-1:0] value;
    logic [4:0]                        reps;
    logic [7:0]                        stride;
    logic                              fixed;
    logic signed [tmsd_pkg::VAL_W-1:0] exp_value;
    logic [tmsd_pkg::CNT_W-1:0]        exp_count;
    logic                              exp_empty;
  } stim_row_t;

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [tmsd_pkg::IN_DATA_W-1:0]  in_tdata;
  logic [tmsd_pkg::IN_USER_W-1:0]  in_tuser;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [tmsd_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                            out_tlast;
  logic                            out_tuser;

  logic signed [tmsd_pkg::VAL_W-1:0] held [0:tmsd_pkg::NUM_LISTS-1][0:tmsd_pkg::LIST_DEPTH-1];
  int                      held_cnt [0:tmsd_pkg::NUM_LISTS-1];
  merge_result_t           pending_results [$];
  merge_result_t           due;
  merge_result_t           no_fixed = '0;
  int                      mismatches = 0;
  int                      cycles = 0;
  bit                      hold_req = 0;
  bit                      tx_steady = 0;

  three_way_sorted_merge_dedup_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [tmsd_pkg::VAL_W-1:0] draw_value(value_spread_t spread);
    case (spread)
      SPREAD_WIDE:   return $urandom;
      SPREAD_NARROW: return $signed($urandom_range(0, 16)) - 8;
      default: begin
        if ($urandom_range(0, 1)) return 32'h7fff_fff0 + $urandom_range(0, 15);
        return 32'h8000_0000 + $urandom_range(0, 15);
      end
    endcase
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatches++;
    $display("mismatch at cycle %0d: %s", cycles, msg);
  endtask

  // Merge the held lists head by head, drop repeats of the previous value, then empty them.
  task automatic merge_lists(input bit use_fixed, input merge_result_t fixed_res);
    int                                pos [0:tmsd_pkg::NUM_LISTS-1];
    logic signed [tmsd_pkg::VAL_W-1:0] merged [0:MAX_MERGED-1];
    logic signed [tmsd_pkg::VAL_W-1:0] best_v;
    int                                best;
    int                                n;
    int                                k;
    merge_result_t                     res;
    n = 0;
    for (k = 0; k < tmsd_pkg::NUM_LISTS; k++) pos[k] = 0;
    best = 0;
    while (best >= 0) begin
      best = -1;
      best_v = '0;
      for (k = 0; k < tmsd_pkg::NUM_LISTS; k++) begin
        if (pos[k] < held_cnt[k] && (best < 0 || held[k][pos[k]] < best_v)) begin
          best = k;
          best_v = held[k][pos[k]];
        end
      end
      if (best >= 0) begin
        pos[best]++;
        if (n == 0 || best_v != merged[n-1]) begin
          merged[n] = best_v;
          n++;
        end
      end
    end
    if (use_fixed) begin
      pending_results.push_back(fixed_res);
    end else if (n == 0) begin
      res = '0;
      res.last = 1'b1;
      res.empty = 1'b1;
      pending_results.push_back(res);
    end else begin
      for (k = 0; k < n; k++) begin
        res.value = merged[k];
        res.last = (k == n - 1);
        res.count = (k == n - 1) ? tmsd_pkg::CNT_W'(n) : '0;
        res.empty = 1'b0;
        pending_results.push_back(res);
      end
    end
    for (k = 0; k < tmsd_pkg::NUM_LISTS; k++) held_cnt[k] = 0;
  endtask

  task automatic send_item(input logic op, input logic [tmsd_pkg::LIST_W-1:0] list,
                           input logic signed [tmsd_pkg::VAL_W-1:0] value,
                           input bit use_fixed, input merge_result_t fixed_res);
    int gap;
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata = value;
    in_tuser = {list, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (op == OP_MERGE) begin
      merge_lists(use_fixed, fixed_res);
    end else if (list < tmsd_pkg::NUM_LISTS && value != 0 &&
                 held_cnt[list] < tmsd_pkg::LIST_DEPTH) begin
      held[list][held_cnt[list]] = value;
      held_cnt[list]++;
    end
    gap = tx_steady ? 0 : idle_len();
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected result value %0d", $signed(out_tdata[31:0])));
      end else begin
        due = pending_results.pop_front();
        if (out_tdata[31:0] !== due.value)
          flag_mismatch($sformatf("merged_value %0d, want %0d",
                                  $signed(out_tdata[31:0]), due.value));
        if (out_tlast !== due.last)
          flag_mismatch($sformatf("is_last %b, want %b", out_tlast, due.last));
        if (out_tdata[37:32] !== due.count)
          flag_mismatch($sformatf("distinct_count %0d, want %0d", out_tdata[37:32], due.count));
        if (out_tuser !== due.empty)
          flag_mismatch($sformatf("is_empty %b, want %b", out_tuser, due.empty));
        if (out_tdata[39:38] !== 2'b00)
          flag_mismatch($sformatf("pad bits %b, want 00", out_tdata[39:38]));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("three_way_sorted_merge_dedup_unit regression: fail");
      $finish;
    end
  end

  initial begin : receiver
    int  stall_left;
    int  steady_left;
    bit  rx_steady;
    stall_left = 0;
    steady_left = 0;
    rx_steady = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready = 1'b0;
        hold_req = 0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
      end else begin
        if (steady_left == 0) begin
          rx_steady = ($urandom_range(0, 3) == 0);
          steady_left = $urandom_range(50, 300);
        end
        steady_left--;
        if (!rx_steady && stall_left > 0) begin
          out_tready = 1'b0;
          stall_left--;
        end else begin
          out_tready = 1'b1;
          if (!rx_steady && $urandom_range(0, 9) < 3) stall_left = idle_len();
        end
      end
    end
  end

  initial begin : stimulus
    stim_row_t                         directed_rows [0:NUM_ROWS-1];
    merge_result_t                     fixed_res;
    logic signed [tmsd_pkg::VAL_W-1:0] seq_vals [0:tmsd_pkg::NUM_LISTS-1][0:tmsd_pkg::LIST_DEPTH];
    logic signed [tmsd_pkg::VAL_W-1:0] tmp;
    int                      seq_len [0:tmsd_pkg::NUM_LISTS-1];
    int                      seq_left [0:tmsd_pkg::NUM_LISTS-1];
    value_spread_t           spread;
    bit                      broken;
    bit                      all_empty;
    int                      r, i, j, k, total, items, seq, sz;

    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    for (k = 0; k < tmsd_pkg::NUM_LISTS; k++) held_cnt[k] = 0;

    directed_rows[0]  = '{OP_MERGE,  2'd0, 32'sd0,         5'd1,  8'd0, 1'b1, 32'sd0, 6'd0, 1'b1};
    directed_rows[1]  = '{OP_APPEND, 2'd0, 32'h8000_0000,  5'd1,  8'd0, 1'b0, 32'sd0, 6'd0, 1'b0};
    directed_rows[2]  = '{OP_APPEND, 2'd1, -32'sd1,        5'd1,  8'd0, 1'b0, 32'sd0, 6'd0, 1'b0};
    directed_rows[3]  = '{OP_APPEND, 2'd1, 32'h7fff_ffff,  5'd1,  8'd0, 1'b0, 32'sd0, 6'd0, 1'b0};
    directed_rows[4]  = '{OP_APPEND, 2'd2, -32'sd1,        5'd1,  8'd0, 1'b0, 32'sd0, 6'd0, 1'b0};
    directed_rows[5]  = '{OP_APPEND, 2'd2, 32'sd1,         5'd1,  8'd0, 1'b0, 32'sd0, 6'd0, 1'b0};
    directed_rows[6]  = '{OP_APPEND, 2'd0, 32'sd0,         5'd1,  8'd0, 1'b0, 32'sd0, 6'd0, 1'b0};
    directed_rows[7]  = '{OP_APPEND, LIST_NONE, 32'sd5,    5'd1,  8'd0, 1'b0, 32'sd0, 6'd0, 1'b0};
    directed_rows[8]  = '{OP_MERGE,  2'd0, 32'sd0,         5'd1,  8'd0, 1'b0, 32'sd0, 6'd0, 1'b0};
    directed_rows[9]  = '{OP_MERGE,  2'd0, 32'sd0,         5'd1,  8'd0, 1'b1, 32'sd0, 6'd0, 1'b1};
    directed_rows[10] = '{OP_APPEND, 2'd1, 32'sd42,        5'd1,  8'd0, 1'b0, 32'sd0, 6'd0, 1'b0};
    directed_rows[11] = '{OP_MERGE,  2'd0, 32'sd0,         5'd1,  8'd0, 1'b1, 32'sd42, 6'd1, 1'b0};
    directed_rows[12] = '{OP_APPEND, 2'd2, 32'sd100,       5'd17, 8'd1, 1'b0, 32'sd0, 6'd0, 1'b0};
    directed_rows[13] = '{OP_APPEND, 2'd0, 32'sd50,        5'd1,  8'd0, 1'b0, 32'sd0, 6'd0, 1'b0};
    directed_rows[14] = '{OP_APPEND, 2'd1, 32'sd100,       5'd1,  8'd0, 1'b0, 32'sd0, 6'd0, 1'b0};
    directed_rows[15] = '{OP_MERGE,  2'd0, 32'sd0,         5'd1,  8'd0, 1'b0, 32'sd0, 6'd0, 1'b0};
    directed_rows[16] = '{OP_APPEND, 2'd0, 32'sd5,         5'd1,  8'd0, 1'b0, 32'sd0, 6'd0, 1'b0};
    directed_rows[17] = '{OP_APPEND, 2'd0, 32'sd3,         5'd1,  8'd0, 1'b0, 32'sd0, 6'd0, 1'b0};
    directed_rows[18] = '{OP_APPEND, 2'd1, 32'sd4,         5'd1,  8'd0, 1'b0, 32'sd0, 6'd0, 1'b0};
    directed_rows[19] = '{OP_APPEND, 2'd2, 32'sd5,         5'd1,  8'd0, 1'b0, 32'sd0, 6'd0, 1'b0};
    directed_rows[20] = '{OP_MERGE,  2'd0, 32'sd0,         5'd1,  8'd0, 1'b0, 32'sd0, 6'd0, 1'b0};
    directed_rows[21] = '{OP_APPEND, 2'd0, 32'h7fff_ffff,  5'd1,  8'd0, 1'b0, 32'sd0, 6'd0, 1'b0};
    directed_rows[22] = '{OP_APPEND, 2'd1, 32'h7fff_ffff,  5'd1,  8'd0, 1'b0, 32'sd0, 6'd0, 1'b0};
    directed_rows[23] = '{OP_APPEND, 2'd2, 32'h7fff_ffff,  5'd1,  8'd0, 1'b0, 32'sd0, 6'd0, 1'b0};
    directed_rows[24] = '{OP_MERGE,  2'd0, 32'sd0,         5'd1,  8'd0, 1'b1, 32'h7fff_ffff,
                          6'd1, 1'b0};

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (r = 0; r < NUM_ROWS; r++) begin
      fixed_res.value = directed_rows[r].exp_value;
      fixed_res.last = 1'b1;
      fixed_res.count = directed_rows[r].exp_count;
      fixed_res.empty = directed_rows[r].exp_empty;
      for (i = 0; i < directed_rows[r].reps; i++)
        send_item(directed_rows[r].op, directed_rows[r].list,
                  directed_rows[r].value + i * directed_rows[r].stride,
                  directed_rows[r].fixed, fixed_res);
    end
    wait_drained();

    items = 0;
    seq = 0;
    while (items < RANDOM_ITEMS) begin
      spread = value_spread_t'($urandom_range(0, 2));
      broken = ($urandom_range(0, 9) == 0);
      all_empty = ($urandom_range(0, 19) == 0);
      tx_steady = ($urandom_range(0, 4) == 0);
      total = 0;
      for (k = 0; k < tmsd_pkg::NUM_LISTS; k++) begin
        r = $urandom_range(0, 99);
        if (seq == 3) sz = tmsd_pkg::LIST_DEPTH;
        else if (all_empty) sz = 0;
        else if (r < 65) sz = $urandom_range(0, 4);
        else if (r < 90) sz = $urandom_range(5, 10);
        else sz = $urandom_range(tmsd_pkg::LIST_DEPTH - 1, tmsd_pkg::LIST_DEPTH + 1);
        for (i = 0; i < sz; i++) seq_vals[k][i] = draw_value(spread);
        if (!broken) begin
          for (i = 1; i < sz; i++) begin
            tmp = seq_vals[k][i];
            j = i - 1;
            while (j >= 0 && seq_vals[k][j] > tmp) begin
              seq_vals[k][j+1] = seq_vals[k][j];
              j--;
            end
            seq_vals[k][j+1] = tmp;
          end
        end
        seq_len[k] = sz;
        seq_left[k] = sz;
        total += sz;
      end
      while (total > 0) begin
        do k = $urandom_range(0, tmsd_pkg::NUM_LISTS - 1); while (seq_left[k] == 0);
        send_item(OP_APPEND, tmsd_pkg::LIST_W'(k), seq_vals[k][seq_len[k] - seq_left[k]],
                  1'b0, no_fixed);
        seq_left[k]--;
        total--;
        items++;
        if ($urandom_range(0, 19) == 0) begin
          if ($urandom_range(0, 1))
            send_item(OP_APPEND, LIST_NONE, $urandom, 1'b0, no_fixed);
          else
            send_item(OP_APPEND,
                      tmsd_pkg::LIST_W'($urandom_range(0, tmsd_pkg::NUM_LISTS - 1)),
                      32'sd0, 1'b0, no_fixed);
        end
      end
      if (seq == 3) hold_req = 1;
      send_item(OP_MERGE, tmsd_pkg::LIST_W'($urandom_range(0, 3)), $urandom, 1'b0, no_fixed);
      items++;
      if (seq % 8 == 0) wait_drained();
      seq++;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("three_way_sorted_merge_dedup_unit regression: pass");
    end else begin
      $display("three_way_sorted_merge_dedup_unit regression: fail");
    end
    $finish;
  end

endmodule
